// File: rtl/capture_frequency_meter_defines.svh
// Assertion macros shared by the capture frequency meter RTL.
`ifndef CAPTURE_FREQUENCY_METER_DEFINES_SVH
`define CAPTURE_FREQUENCY_METER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CFM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CFM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cfm_pkg.sv
// Shared constants, types and the segment decoder of the capture frequency meter.
`default_nettype none

package cfm_pkg;

  localparam int unsigned CAPTURE_WIDTH = 16;
  localparam int unsigned NUM_WIDTH     = 24;
  localparam int unsigned DIGIT_COUNT   = 4;
  localparam int unsigned SEG_WIDTH     = 8;
  localparam int unsigned POS_WIDTH     = 2;
  localparam int unsigned BCD_WIDTH     = 4;

  localparam int unsigned APB_ADDR_WIDTH = 3;
  localparam int unsigned APB_DATA_WIDTH = 32;
  // Register index as seen in paddr[APB_ADDR_WIDTH-1] (word address bit)
  localparam logic REG_IDX_CLOCK_NUMERATOR = 1'b0;

  localparam logic [NUM_WIDTH-1:0] NUM_RESET = NUM_WIDTH'(8000000);

  function automatic longint unsigned pow10(input int unsigned n);
    longint unsigned acc;
    acc = 1;
    for (int unsigned i = 0; i < n; i++) begin
      acc = acc * 10;
    end
    return acc;
  endfunction

  localparam longint unsigned MAX_DISPLAY = pow10(DIGIT_COUNT) - 1;
  localparam int unsigned FREQ_WIDTH = $clog2(MAX_DISPLAY + 1);
  localparam int unsigned CMP_WIDTH  = (NUM_WIDTH > FREQ_WIDTH) ? NUM_WIDTH : FREQ_WIDTH;
  localparam int unsigned CNT_WIDTH  = $clog2(NUM_WIDTH + 1);

  // Divide by ten as multiply by a rounded-up reciprocal; exact for FREQ_WIDTH-bit values
  localparam int unsigned     RECIP_SHIFT = FREQ_WIDTH + 4;
  localparam longint unsigned RECIP_TEN   = ((64'd1 << RECIP_SHIFT) / 10) + 1;
  localparam int unsigned     RECIP_WIDTH = $clog2(RECIP_TEN + 1);
  localparam int unsigned     PROD_WIDTH  = FREQ_WIDTH + RECIP_WIDTH;

  localparam logic [BCD_WIDTH-1:0] DIGIT_NINE = BCD_WIDTH'(9);
  localparam logic [SEG_WIDTH-1:0] SEG_BLANK  = 8'hff;

  // Active-low segment patterns, gfedcba order with dp in bit 7
  function automatic logic [SEG_WIDTH-1:0] seg_code(input logic [BCD_WIDTH-1:0] digit);
    logic [SEG_WIDTH-1:0] code;
    unique case (digit)
      4'd0:    code = 8'hc0;
      4'd1:    code = 8'hf9;
      4'd2:    code = 8'ha4;
      4'd3:    code = 8'hb0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hf8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h90;
      default: code = SEG_BLANK;
    endcase
    return code;
  endfunction

  localparam logic [SEG_WIDTH-1:0] SEG_NINE = seg_code(DIGIT_NINE);
  localparam logic [CNT_WIDTH-1:0] LAST_DIGIT_IDX = CNT_WIDTH'(DIGIT_COUNT - 1);
  localparam logic [POS_WIDTH-1:0] LAST_POS = POS_WIDTH'(DIGIT_COUNT - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_EMIT = 4'b1000
  } cfm_state_e;

  typedef struct packed {
    logic                 hold;    // store first capture of a pair
    logic                 start;   // load divider from second capture
    logic                 step;    // one restoring divide iteration
    logic                 finish;  // saturate quotient into digit register
    logic                 emit;    // peel one digit into the output register
    logic [CNT_WIDTH-1:0] idx;     // digit index during emit
  } cfm_cmd_t;

  typedef struct packed {
    logic out_free;
  } cfm_stat_t;

endpackage

`default_nettype wire

// File: rtl/cfm_if.sv
// Valid/ready channel interfaces for capture requests and segment results.
`default_nettype none

interface cfm_cap_if import cfm_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic [CAPTURE_WIDTH-1:0] capture_value;

  modport source (output valid, output capture_value, input ready);
  modport sink   (input valid, input capture_value, output ready);
endinterface

interface cfm_seg_if import cfm_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic [SEG_WIDTH-1:0] segment_code;
  logic [POS_WIDTH-1:0] digit_position;
  logic                 overflow;
  logic                 last;

  modport source (output valid, output segment_code, output digit_position,
                  output overflow, output last, input ready);
  modport sink   (input valid, input segment_code, input digit_position,
                  input overflow, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/cfm_ctrl.sv
// Sequencer for capture pairing, divide iterations and digit emission.
`default_nettype none

module cfm_ctrl import cfm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cap_valid_i,
  output logic           cap_ready_o,
  input  wire cfm_stat_t stat_i,
  output cfm_cmd_t       cmd_o
);

  cfm_state_e           state_q, state_d;
  logic [CNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                 have_first_q, have_first_d;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    have_first_d = have_first_q;
    cmd_o        = '0;
    cmd_o.idx    = cnt_q;
    cap_ready_o  = (state_q == ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (cap_valid_i) begin
          if (!have_first_q) begin
            cmd_o.hold   = 1'b1;
            have_first_d = 1'b1;
          end else begin
            cmd_o.start  = 1'b1;
            have_first_d = 1'b0;
            cnt_d        = CNT_WIDTH'(NUM_WIDTH - 1);
            state_d      = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        cnt_d        = '0;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (cnt_q == LAST_DIGIT_IDX) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      have_first_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      have_first_q <= have_first_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/cfm_datapath.sv
// Period subtractor, restoring divider, digit splitter and output register.
`default_nettype none

module cfm_datapath import cfm_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [CAPTURE_WIDTH-1:0] capture_value_i,
  input  wire logic [NUM_WIDTH-1:0]     clock_numerator_i,
  input  wire cfm_cmd_t                 cmd_i,
  output cfm_stat_t                     stat_o,
  input  wire logic                     out_ready_i,
  output logic                          out_valid_o,
  output logic [SEG_WIDTH-1:0]          segment_code_o,
  output logic [POS_WIDTH-1:0]          digit_position_o,
  output logic                          overflow_o,
  output logic                          last_o
);

  logic [CAPTURE_WIDTH-1:0] held_q;
  logic [CAPTURE_WIDTH-1:0] divisor_q;
  logic [CAPTURE_WIDTH-1:0] rem_q;
  logic [NUM_WIDTH-1:0]     quo_q;     // dividend shifts out, quotient shifts in
  logic                     zero_q;
  logic [FREQ_WIDTH-1:0]    freq_q;
  logic                     ovf_q;
  logic                     out_valid_q;
  logic [SEG_WIDTH-1:0]     seg_q;
  logic [POS_WIDTH-1:0]     pos_q;
  logic                     out_ovf_q;
  logic                     last_q;

  logic [CAPTURE_WIDTH:0]   rem_sh;
  logic                     fits;
  logic                     sat;
  logic [PROD_WIDTH-1:0]    prod;
  logic [FREQ_WIDTH-1:0]    tenth;
  logic [BCD_WIDTH-1:0]     digit;

  assign rem_sh = {rem_q, quo_q[NUM_WIDTH-1]};
  assign fits   = (rem_sh >= {1'b0, divisor_q});
  assign sat    = zero_q || (CMP_WIDTH'(quo_q) > CMP_WIDTH'(MAX_DISPLAY));

  assign prod  = PROD_WIDTH'(freq_q) * PROD_WIDTH'(RECIP_TEN);
  assign tenth = FREQ_WIDTH'(prod >> RECIP_SHIFT);
  assign digit = BCD_WIDTH'(freq_q - FREQ_WIDTH'(tenth * FREQ_WIDTH'(10)));

  always_ff @(posedge clk_i) begin
    if (cmd_i.hold) begin
      held_q <= capture_value_i;
    end
    if (cmd_i.start) begin
      divisor_q <= capture_value_i - held_q;
      zero_q    <= (capture_value_i == held_q);
      rem_q     <= '0;
      quo_q     <= clock_numerator_i;
    end else if (cmd_i.step) begin
      if (fits) begin
        rem_q <= CAPTURE_WIDTH'(rem_sh - {1'b0, divisor_q});
      end else begin
        rem_q <= rem_sh[CAPTURE_WIDTH-1:0];
      end
      quo_q <= {quo_q[NUM_WIDTH-2:0], fits};
    end
    if (cmd_i.finish) begin
      freq_q <= sat ? FREQ_WIDTH'(MAX_DISPLAY) : FREQ_WIDTH'(quo_q);
      ovf_q  <= sat;
    end else if (cmd_i.emit) begin
      freq_q <= tenth;
    end
    if (cmd_i.emit) begin
      seg_q     <= seg_code(digit);
      pos_q     <= POS_WIDTH'(cmd_i.idx);
      out_ovf_q <= ovf_q;
      last_q    <= (cmd_i.idx == LAST_DIGIT_IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign segment_code_o   = seg_q;
  assign digit_position_o = pos_q;
  assign overflow_o       = out_ovf_q;
  assign last_o           = last_q;

endmodule

`default_nettype wire

// File: rtl/capture_frequency_meter.sv
// Top level of the capture frequency meter: APB register, controller and datapath.
`default_nettype none

// Reciprocal frequency meter. Capture requests are taken in pairs: the first is
// held and produces nothing, the second gives period = (second - first) mod 2^16,
// and the frequency floor(clock_numerator / period) is shown as four active-low
// seven-segment digits, ones digit first, the thousands digit flagged last. A
// zero period or a quotient above 9999 shows 9999 with overflow set on every
// digit. The first capture of a pair is only held. The second is accepted, then
// runs through the bit-serial restoring divider (one quotient bit per cycle), a
// saturation step and then the digit splitter, one digit per cycle into the
// output register whenever that register is free; a stalled output holds the
// splitter. Capture requests are refused while a measurement is in the
// divider or the digit splitter; the last digit may still be waiting in the
// output register when the next capture is taken. clock_numerator sits at byte
// address 0 of the APB port (reset 8000000) and is to be written only while the
// meter is idle.

`include "capture_frequency_meter_defines.svh"

module capture_frequency_meter import cfm_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  cfm_cap_if.sink                        cap_i,
  cfm_seg_if.source                      seg_o,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [APB_ADDR_WIDTH-1:0] paddr,
  input  wire logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0]      prdata,
  output logic                           pready
);

  logic [NUM_WIDTH-1:0] clock_numerator_q;
  logic                 num_sel;
  cfm_cmd_t             cmd;
  cfm_stat_t            stat;

  // --- configuration: single register, decoded on the word-address bit ---
  assign pready  = 1'b1;
  assign num_sel = (paddr[APB_ADDR_WIDTH-1] == REG_IDX_CLOCK_NUMERATOR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_numerator_q <= NUM_RESET;
    end else if (psel && penable && pwrite && num_sel) begin
      clock_numerator_q <= pwdata[NUM_WIDTH-1:0];
    end
  end

  assign prdata = num_sel ? APB_DATA_WIDTH'(clock_numerator_q) : '0;

  // --- sequencer: pairing, divide count, digit count ---
  cfm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_valid_i (cap_i.valid),
    .cap_ready_o (cap_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // --- datapath: period, divider, digit split, output register ---
  cfm_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .capture_value_i   (cap_i.capture_value),
    .clock_numerator_i (clock_numerator_q),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_ready_i       (seg_o.ready),
    .out_valid_o       (seg_o.valid),
    .segment_code_o    (seg_o.segment_code),
    .digit_position_o  (seg_o.digit_position),
    .overflow_o        (seg_o.overflow),
    .last_o            (seg_o.last)
  );

  // --- checks ---
  // Starting a divide must close the capture request side on the next cycle.
  `CFM_ASSERT_NEXT(a_start_blocks_input, clk_i, rst_ni, cmd.start, !cap_i.ready, "capture taken during divide")
  // The flagged final digit is always the most significant place.
  `CFM_ASSERT_IMPLY(a_last_position, clk_i, rst_ni, seg_o.valid && seg_o.last, seg_o.digit_position == LAST_POS, "last on wrong digit")
  // Overflow saturates to all nines, so every flagged digit shows a nine.
  `CFM_ASSERT_IMPLY(a_overflow_nines, clk_i, rst_ni, seg_o.valid && seg_o.overflow, seg_o.segment_code == SEG_NINE, "overflow digit not nine")

endmodule

`default_nettype wire
